// ===== hdl/vlpq_pkg.sv =====
// package for the variable length packet ring queue
// holds sizes, command and status codes, item structs and the sequencer states
// no dependencies
package vlpq_pkg;

  localparam int unsigned QUEUE_BYTES  = 65536;
  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned STORE_SIZE   = QUEUE_BYTES + HEADER_BYTES;
  localparam int unsigned ADDR_W       = $clog2(STORE_SIZE);
  localparam int unsigned CUR_W        = ADDR_W + 1;
  localparam int unsigned HCNT_W       = $clog2(HEADER_BYTES);
  localparam int unsigned HDR_W        = 8 * HEADER_BYTES;

  typedef logic [ADDR_W-1:0] ptr_t;
  typedef logic [CUR_W-1:0]  cur_t;

  typedef enum logic [1:0] {
    CMD_PUT_START = 2'd0,
    CMD_PUT_BYTE  = 2'd1,
    CMD_GET_START = 2'd2,
    CMD_GET_BYTE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DROP    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_TOO_BIG = 3'd3,
    ST_BYTE    = 3'd4,
    ST_BAD_CMD = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_MARK,
    S_HDR_WR,
    S_GET_CHK,
    S_HDR_RD,
    S_HDR_WAIT,
    S_HDR_EVAL,
    S_BYTE_WAIT,
    S_RESP
  } state_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] length;
    logic [7:0]  data_in;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] packet_length;
    logic [7:0]  data_out;
    logic        last_byte;
  } out_item_t;

  typedef struct packed {
    logic       we;
    logic       re;
    ptr_t       addr;
    logic [7:0] wdata;
  } mem_req_t;

endpackage

// ===== hdl/vlpq_store.sv =====
// byte store of the packet ring, one port, registered read data
// depends on vlpq_pkg
module vlpq_store (
  input  logic               clk_i,
  input  vlpq_pkg::mem_req_t req_i,
  output logic [7:0]         rdata_o
);
  import vlpq_pkg::*;

  logic [7:0] mem_q [STORE_SIZE];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/vlpq_ctrl.sv =====
// sequencer of the packet ring: pointers, header writes and reads, byte transfers
// depends on vlpq_pkg, drives the port of vlpq_store
module vlpq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vlpq_pkg::in_item_t  in_item_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output vlpq_pkg::out_item_t res_o,
  output vlpq_pkg::mem_req_t  mem_req_o,
  input  logic [7:0]          mem_rdata_i
);
  import vlpq_pkg::*;

  localparam cur_t QB  = cur_t'(QUEUE_BYTES);
  localparam cur_t HB  = cur_t'(HEADER_BYTES);
  localparam cur_t SSZ = cur_t'(STORE_SIZE);

  state_e            state_q, state_d;
  in_item_t          item_q, item_d;
  ptr_t              wp_q, wp_d, rp_q, rp_d, pc_q, pc_d, base_q, base_d;
  cur_t              gc_q, gc_d;
  logic [15:0]       pl_q, pl_d, gl_q, gl_d;
  logic              pa_q, pa_d, wrap_q, wrap_d;
  logic [HCNT_W-1:0] cnt_q, cnt_d;
  logic [HDR_W-1:0]  hdr_q, hdr_d;
  logic              hrd_q, hrd_d, oor_q, oor_d;
  out_item_t         res_q, res_d;

  cur_t              acc_addr, need, end_addr, wp_w, rp_w;
  logic              acc_we, acc_re, tail_ok, head_ok, mid_ok;
  logic [7:0]        rbyte;
  logic [15:0]       hsize;

  function automatic ptr_t clamp_rd(cur_t e, ptr_t wp);
    return (e > QB) ? wp : e[ADDR_W-1:0];
  endfunction

  assign wp_w     = {1'b0, wp_q};
  assign rp_w     = {1'b0, rp_q};
  assign need     = cur_t'(item_q.length) + HB;
  assign tail_ok  = (wp_w <= QB) && (need < QB - wp_w);
  assign head_ok  = (rp_q != '0) && (need < rp_w - cur_t'(1));
  assign mid_ok   = need < rp_w - wp_w;
  assign rbyte    = oor_q ? 8'h00 : mem_rdata_i;
  assign hsize    = hdr_q[15:0];
  assign end_addr = {1'b0, base_q} + HB + cur_t'(hsize);

  always_comb begin
    mem_req_o.we    = acc_we && (acc_addr < SSZ);
    mem_req_o.re    = acc_re && (acc_addr < SSZ);
    mem_req_o.addr  = acc_addr[ADDR_W-1:0];
    mem_req_o.wdata = 8'hFF;
    unique case (state_q)
      S_HDR_WR: begin
        unique case (cnt_q)
          HCNT_W'(0): mem_req_o.wdata = item_q.length[7:0];
          HCNT_W'(1): mem_req_o.wdata = item_q.length[15:8];
          default:    mem_req_o.wdata = 8'h00;
        endcase
      end
      S_EXEC:  mem_req_o.wdata = item_q.data_in;
      default: mem_req_o.wdata = 8'hFF;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    item_d   = item_q;
    wp_d     = wp_q;
    rp_d     = rp_q;
    pc_d     = pc_q;
    base_d   = base_q;
    gc_d     = gc_q;
    pl_d     = pl_q;
    gl_d     = gl_q;
    pa_d     = pa_q;
    wrap_d   = wrap_q;
    cnt_d    = cnt_q;
    hdr_d    = hrd_q ? {rbyte, hdr_q[HDR_W-1:8]} : hdr_q;
    res_d    = res_q;
    acc_we   = 1'b0;
    acc_re   = 1'b0;
    acc_addr = '0;
    hrd_d    = 1'b0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d  = in_item_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_d   = '0;
        state_d = S_RESP;
        unique case (item_q.cmd)
          CMD_PUT_START: begin
            pl_d  = item_q.length;
            pa_d  = 1'b0;
            cnt_d = '0;
            if (wp_q >= rp_q) begin
              if (tail_ok) begin
                base_d  = wp_q;
                state_d = S_HDR_WR;
              end else if (head_ok) begin
                base_d  = '0;
                state_d = S_MARK;
              end else begin
                res_d.status = ST_DROP;
              end
            end else if (mid_ok) begin
              base_d  = wp_q;
              state_d = S_HDR_WR;
            end else begin
              res_d.status = ST_DROP;
            end
          end
          CMD_PUT_BYTE: begin
            if (pl_q == '0) begin
              res_d.status = ST_BAD_CMD;
            end else begin
              pl_d = pl_q - 16'd1;
              if (pa_q) begin
                acc_we       = 1'b1;
                acc_addr     = {1'b0, pc_q};
                pc_d         = pc_q + ptr_t'(1);
                res_d.status = ST_OK;
              end else begin
                res_d.status = ST_DROP;
              end
              if (pl_q == 16'd1) begin
                res_d.last_byte = 1'b1;
                pa_d            = 1'b0;
                if (pa_q) begin
                  wp_d = pc_q + ptr_t'(1);
                end
              end
            end
          end
          CMD_GET_START: begin
            if (gl_q != '0) begin
              rp_d = clamp_rd(gc_q + cur_t'(gl_q), wp_q);
              gl_d = '0;
            end
            state_d = S_GET_CHK;
          end
          CMD_GET_BYTE: begin
            if (gl_q == '0) begin
              res_d.status = ST_BAD_CMD;
            end else begin
              acc_re   = 1'b1;
              acc_addr = gc_q;
              state_d  = S_BYTE_WAIT;
            end
          end
          default: res_d.status = ST_BAD_CMD;
        endcase
      end
      S_MARK: begin
        acc_we   = 1'b1;
        acc_addr = wp_w + cur_t'(cnt_q);
        cnt_d    = cnt_q + HCNT_W'(1);
        if (cnt_q == HCNT_W'(HEADER_BYTES - 1)) begin
          state_d = S_HDR_WR;
        end
      end
      S_HDR_WR: begin
        acc_we   = 1'b1;
        acc_addr = {1'b0, base_q} + cur_t'(cnt_q);
        cnt_d    = cnt_q + HCNT_W'(1);
        if (cnt_q == HCNT_W'(HEADER_BYTES - 1)) begin
          pc_d = base_q + ptr_t'(HEADER_BYTES);
          pa_d = 1'b1;
          if (item_q.length == '0) begin
            wp_d = base_q + ptr_t'(HEADER_BYTES);
          end
          res_d.status = ST_OK;
          state_d      = S_RESP;
        end
      end
      S_GET_CHK: begin
        if (wp_q == rp_q) begin
          res_d.status = ST_EMPTY;
          state_d      = S_RESP;
        end else begin
          base_d  = rp_q;
          wrap_d  = 1'b0;
          cnt_d   = '0;
          state_d = S_HDR_RD;
        end
      end
      S_HDR_RD: begin
        acc_re   = 1'b1;
        acc_addr = {1'b0, base_q} + cur_t'(cnt_q);
        hrd_d    = 1'b1;
        cnt_d    = cnt_q + HCNT_W'(1);
        if (cnt_q == HCNT_W'(HEADER_BYTES - 1)) begin
          state_d = S_HDR_WAIT;
        end
      end
      S_HDR_WAIT: begin
        state_d = S_HDR_EVAL;
      end
      S_HDR_EVAL: begin
        if (!wrap_q && (hdr_q == '1)) begin
          base_d  = '0;
          rp_d    = '0;
          wrap_d  = 1'b1;
          cnt_d   = '0;
          state_d = S_HDR_RD;
        end else begin
          res_d.packet_length = hsize;
          state_d             = S_RESP;
          if (hsize > item_q.length) begin
            res_d.status = ST_TOO_BIG;
            rp_d         = clamp_rd(end_addr, wp_q);
          end else begin
            res_d.status = ST_OK;
            gc_d         = {1'b0, base_q} + HB;
            gl_d         = hsize;
            if (hsize == '0) begin
              rp_d = clamp_rd(end_addr, wp_q);
            end
          end
        end
      end
      S_BYTE_WAIT: begin
        res_d.status   = ST_BYTE;
        res_d.data_out = rbyte;
        gc_d           = gc_q + cur_t'(1);
        gl_d           = gl_q - 16'd1;
        if (gl_q == 16'd1) begin
          res_d.last_byte = 1'b1;
          rp_d            = clamp_rd(gc_q + cur_t'(1), wp_q);
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign oor_d = acc_addr >= SSZ;
  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wp_q    <= '0;
      rp_q    <= '0;
      pc_q    <= '0;
      gc_q    <= '0;
      pl_q    <= '0;
      gl_q    <= '0;
      pa_q    <= 1'b0;
      wrap_q  <= 1'b0;
      cnt_q   <= '0;
      hrd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      pc_q    <= pc_d;
      gc_q    <= gc_d;
      pl_q    <= pl_d;
      gl_q    <= gl_d;
      pa_q    <= pa_d;
      wrap_q  <= wrap_d;
      cnt_q   <= cnt_d;
      hrd_q   <= hrd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    base_q <= base_d;
    hdr_q  <= hdr_d;
    oor_q  <= oor_d;
    res_q  <= res_d;
  end

endmodule

// ===== hdl/variable_length_packet_ring_queue_unit.sv =====
// put_start writes a header and get_start reads one, the longest paths from item accept to result
// valid; both grow when a wrap marker is written or skipped, while put_byte, get_byte, a dropped
// put_start, an empty get_start and a bad command take a shorter path
// throughput: one item at a time over the single store port;
// the output register lets the next item in while a result waits
// reset clears pointers, counters and valid flags, not the byte store; uses vlpq_pkg, vlpq_ctrl, vlpq_store
module variable_length_packet_ring_queue_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vlpq_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vlpq_pkg::out_item_t out_item_o
);
  import vlpq_pkg::*;

  mem_req_t   mem_req;
  logic [7:0] mem_rdata;
  logic       res_valid, res_ready;
  out_item_t  res;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_item_q;

  vlpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  vlpq_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== hdl/vlpq_checker.sv =====
// port checker for the packet ring queue, bound to the top level
// depends on vlpq_pkg and variable_length_packet_ring_queue_unit
module vlpq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input vlpq_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input vlpq_pkg::out_item_t out_item_o
);
  import vlpq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in flight");

  a_data_only_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ST_BYTE |->
      out_item_o.data_out == 8'h00)
    else $error("data on a result that is not a byte");

  a_len_only_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.packet_length != 16'h0000 |->
      out_item_o.status == ST_OK || out_item_o.status == ST_TOO_BIG)
    else $error("packet length on a wrong result");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.last_byte |->
      out_item_o.status == ST_OK || out_item_o.status == ST_DROP ||
      out_item_o.status == ST_BYTE)
    else $error("last byte flag on a wrong result");

endmodule

bind variable_length_packet_ring_queue_unit vlpq_checker u_vlpq_checker (.*);
